>>> rtl/llsr_pkg.sv
// Shared types and constants for the light level step regulator.
package llsr_pkg;

    localparam int unsigned TargetMax = 4095;
    localparam int unsigned LevelMax  = 255;

    // x / 3 for x < 2048 as (x * 683) >> 11
    localparam int unsigned Div3Mul   = 683;
    localparam int unsigned Div3Shift = 11;

    localparam logic [11:0] TOL_RST    = 12'd10;
    localparam logic [8:0]  MAXST_RST  = 9'd300;
    localparam logic [7:0]  PAUSE_RST  = 8'd50;
    localparam logic [3:0]  NOTIFY_RST = 4'd10;

    // configuration register indexes
    localparam logic [1:0] CFG_TOLERANCE    = 2'd0;
    localparam logic [1:0] CFG_MAX_STEPS    = 2'd1;
    localparam logic [1:0] CFG_PAUSE_TICKS  = 2'd2;
    localparam logic [1:0] CFG_NOTIFY_EVERY = 2'd3;

    // request kinds
    localparam logic REQ_SET  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // result status codes
    localparam logic [1:0] ST_SET_OK  = 2'd0;
    localparam logic [1:0] ST_SET_REJ = 2'd1;
    localparam logic [1:0] ST_TICK    = 2'd2;

    // mode codes as reported on the output
    localparam logic [1:0] MODE_CODE_REG   = 2'd0;
    localparam logic [1:0] MODE_CODE_STOP  = 2'd1;
    localparam logic [1:0] MODE_CODE_PAUSE = 2'd2;

    typedef enum logic [2:0] {
        t_mode_reg   = 3'b001,
        t_mode_stop  = 3'b010,
        t_mode_pause = 3'b100
    } t_mode;

    typedef struct packed {
        logic [11:0] light_reading;
        logic [7:0]  led_blue;
        logic [7:0]  led_green;
        logic [7:0]  led_red;
        logic [15:0] target_request;
    } t_in_data;

    typedef struct packed {
        logic [1:0] mode_now;
        logic       notify;
        logic [7:0] drive_level;
        logic       drive_write;
    } t_out_data;

endpackage

>>> rtl/light_level_step_regulator_top.sv
// Light level step regulator: input register, one pass of decision logic, result register.

// The block takes one beat per clock while the result register is free or being
// taken, and returns one result beat for every input beat. An input register holds
// the accepted beat, which moves into the result register when that register is
// empty or its beat is being taken. The regulation state
// (mode, held level, target, step/notify/pause counters) updates in the same
// cycle the beat moves into the result register, so beats back to back see each
// other's state. The input side stays ready while a result waits as long as the
// input register is empty or draining. Configuration writes are taken at once.
module light_level_step_regulator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_idx,
    input  logic [11:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // target_request[15:0], led_red[23:16], led_green[31:24], led_blue[39:32],
    // light_reading[51:40], zero fill [55:52]
    input  logic [55:0] s_axis_tdata,
    // req_type[0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // drive_write[0], drive_level[8:1], notify[9], mode_now[11:10], zero fill [15:12]
    output logic [15:0] m_axis_tdata,
    // status[1:0]
    output logic [1:0]  m_axis_tuser
);

    logic [11:0] r_tolerance;
    logic [8:0]  r_max_steps;
    logic [7:0]  r_pause_ticks;
    logic [3:0]  r_notify_every;

    llsr_pkg::t_mode r_mode, n_mode;
    logic [7:0]  r_held, n_held;
    logic [11:0] r_target, n_target;
    logic [8:0]  r_step_cnt, n_step_cnt;
    logic [3:0]  r_notify_cnt, n_notify_cnt;
    logic [7:0]  r_pause_cnt, n_pause_cnt;

    logic                 r_in_valid;
    logic                 r_in_req;
    llsr_pkg::t_in_data   r_in;
    logic                 r_out_valid;
    llsr_pkg::t_out_data  r_out;
    logic [1:0]           r_out_status;

    logic                 advance;
    llsr_pkg::t_out_data  n_out;
    logic [1:0]           n_status;

    logic [9:0]  rgb_sum;
    logic [19:0] rgb_prod;
    logic [7:0]  rgb_mean;
    logic [11:0] abs_diff;
    logic        target_above;
    logic        run;
    logic [8:0]  pause_next;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // mean of the read-back by reciprocal multiply
    assign rgb_sum  = {2'b00, r_in.led_red} + {2'b00, r_in.led_green}
                    + {2'b00, r_in.led_blue};
    assign rgb_prod = {10'd0, rgb_sum} * 20'(llsr_pkg::Div3Mul);
    assign rgb_mean = rgb_prod[llsr_pkg::Div3Shift +: 8];

    assign target_above = r_target > r_in.light_reading;
    assign abs_diff     = target_above ? (r_target - r_in.light_reading)
                                       : (r_in.light_reading - r_target);
    assign pause_next   = {1'b0, r_pause_cnt} + 9'd1;

    always_comb begin
        n_mode       = r_mode;
        n_held       = r_held;
        n_target     = r_target;
        n_step_cnt   = r_step_cnt;
        n_notify_cnt = r_notify_cnt;
        n_pause_cnt  = r_pause_cnt;
        n_out.drive_write = 1'b0;
        n_out.notify      = 1'b0;
        run          = 1'b0;
        n_status     = llsr_pkg::ST_TICK;

        if (r_in_req == llsr_pkg::REQ_SET) begin
            if (r_in.target_request > 16'(llsr_pkg::TargetMax)) begin
                n_status = llsr_pkg::ST_SET_REJ;
            end else begin
                n_status          = llsr_pkg::ST_SET_OK;
                n_target          = r_in.target_request[11:0];
                n_held            = rgb_mean;
                n_out.drive_write = 1'b1;
                n_out.notify      = 1'b1;
                n_mode            = llsr_pkg::t_mode_reg;
                n_step_cnt        = '0;
                n_notify_cnt      = '0;
                n_pause_cnt       = '0;
            end
        end else begin
            case (r_mode)
                llsr_pkg::t_mode_pause: begin
                    if (pause_next >= {1'b0, r_pause_ticks}) begin
                        n_mode       = llsr_pkg::t_mode_reg;
                        n_step_cnt   = '0;
                        n_notify_cnt = '0;
                        n_pause_cnt  = '0;
                        run          = 1'b1;
                    end else begin
                        n_pause_cnt = pause_next[7:0];
                    end
                end
                llsr_pkg::t_mode_reg: run = 1'b1;
                default: ;
            endcase

            if (run) begin
                // counters here are the post-resume values
                if (n_step_cnt >= r_max_steps) begin
                    n_mode = llsr_pkg::t_mode_stop;
                end else if (r_in.led_red != r_held || r_in.led_green != r_held
                             || r_in.led_blue != r_held) begin
                    n_mode = llsr_pkg::t_mode_stop;
                end else if ((abs_diff < r_tolerance)
                             || (target_above && r_held == 8'(llsr_pkg::LevelMax))
                             || (!target_above && r_held == 8'd0)) begin
                    n_mode       = llsr_pkg::t_mode_pause;
                    n_pause_cnt  = '0;
                    n_out.notify = 1'b1;
                end else begin
                    n_held            = target_above ? r_held + 8'd1 : r_held - 8'd1;
                    n_out.drive_write = 1'b1;
                    n_step_cnt        = n_step_cnt + 9'd1;
                    if ({1'b0, n_notify_cnt} + 5'd1 >= {1'b0, r_notify_every}) begin
                        n_notify_cnt = '0;
                        n_out.notify = 1'b1;
                    end else begin
                        n_notify_cnt = n_notify_cnt + 4'd1;
                    end
                end
            end
        end

        n_out.drive_level = n_held;
        case (n_mode)
            llsr_pkg::t_mode_reg:   n_out.mode_now = llsr_pkg::MODE_CODE_REG;
            llsr_pkg::t_mode_pause: n_out.mode_now = llsr_pkg::MODE_CODE_PAUSE;
            default:                n_out.mode_now = llsr_pkg::MODE_CODE_STOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance    <= llsr_pkg::TOL_RST;
            r_max_steps    <= llsr_pkg::MAXST_RST;
            r_pause_ticks  <= llsr_pkg::PAUSE_RST;
            r_notify_every <= llsr_pkg::NOTIFY_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                llsr_pkg::CFG_TOLERANCE:    r_tolerance    <= i_cfg_data;
                llsr_pkg::CFG_MAX_STEPS:    r_max_steps    <= i_cfg_data[8:0];
                llsr_pkg::CFG_PAUSE_TICKS:  r_pause_ticks  <= i_cfg_data[7:0];
                llsr_pkg::CFG_NOTIFY_EVERY: r_notify_every <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= llsr_pkg::t_mode_stop;
            r_held       <= '0;
            r_target     <= '0;
            r_step_cnt   <= '0;
            r_notify_cnt <= '0;
            r_pause_cnt  <= '0;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_mode       <= n_mode;
                r_held       <= n_held;
                r_target     <= n_target;
                r_step_cnt   <= n_step_cnt;
                r_notify_cnt <= n_notify_cnt;
                r_pause_cnt  <= n_pause_cnt;
                r_out_valid  <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_req <= s_axis_tuser;
            r_in     <= llsr_pkg::t_in_data'(s_axis_tdata[51:0]);
        end
        if (advance) begin
            r_out        <= n_out;
            r_out_status <= n_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out};
    assign m_axis_tuser  = r_out_status;

endmodule
